[rtl/core/hidden_bit_extract_packer_macros.svh]
// Assertion macros for the hidden bit extract packer.
// Included by the top level; no other dependencies.
`ifndef HIDDEN_BIT_EXTRACT_PACKER_MACROS_SVH
`define HIDDEN_BIT_EXTRACT_PACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HBE_ASSERT_IMPL(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define HBE_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) else $error(msg);
`else
`define HBE_ASSERT_IMPL(lbl, clk_s, rst_n_s, prop, msg)
`define HBE_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond, msg)
`endif
`endif

[rtl/core/hbe_pkg.sv]
// Shared constants, register indexes and command/status types for the packer.
// No dependencies.
`timescale 1ns / 1ps
package hbe_pkg;
	localparam int BPS_W       = 9;
	localparam int RATE_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CREDIT_W    = 16;
	localparam int SPF_W       = 11;
	localparam int ACC_W       = 21;
	localparam int FRAMES_PER_SEC = 50;
	localparam int SPF_SHIFT   = 22;
	localparam int SPF_RECIP_I = ((1 << SPF_SHIFT) + FRAMES_PER_SEC - 1) / FRAMES_PER_SEC;
	localparam logic [16:0] SPF_RECIP = 17'(SPF_RECIP_I);

	localparam logic [2:0] MAX_GRANT   = 3'd6;
	localparam logic [2:0] NIBBLE_BITS = 3'd4;

	localparam logic [BPS_W-1:0]  DEFAULT_BPS  = 9'd250;
	localparam logic [RATE_W-1:0] DEFAULT_RATE = 16'd48000;

	localparam logic [CFG_IDX_W-1:0] REG_BPS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ  = 2'd2;

	typedef struct packed {
		logic load;
		logic spf;
		logic mul;
		logic div;
		logic plan;
		logic append;
		logic flush;
	} hbe_cmd_t;

	typedef struct packed {
		logic div_done;
		logic rem_zero;
		logic out_free;
	} hbe_stat_t;
endpackage

[rtl/core/hbe_in_if.sv]
// Input channel: frame word with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface hbe_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] hidden_word;
	logic [7:0] frame_bit_count;
	modport source (output valid, action, hidden_word, frame_bit_count, input ready);
	modport sink (input valid, action, hidden_word, frame_bit_count, output ready);
endinterface

[rtl/core/hbe_out_if.sv]
// Output channel: packed byte word with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
interface hbe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_of_item;
	modport source (output valid, data_byte, last_of_item, input ready);
	modport sink (input valid, data_byte, last_of_item, output ready);
endinterface

[rtl/core/hidden_bit_extract_packer.sv]
// Top level of the hidden bit extract packer: sequencer plus datapath.
// Depends on hbe_pkg, hbe_in_if, hbe_out_if, hbe_ctrl, hbe_dp and the macro header.
//
//   channel    direction  word
//   frame_in   sink       action, hidden_word, frame_bit_count
//   byte_out   source     data_byte, last_of_item
//   cfg_*      write      cfg_index selects register, cfg_data carries value
//
// A frame word passes, from its accept cycle to the next accept, through the
// frame-rate and credit multiplies, up to six compare-and-subtract steps of the grant
// divider and a closing compare, a plan step, then one append step per nibble or bit
// group plus a closing step. A flush passes from its accept to a single flush step.
// Reset is asynchronous; control and state registers return to their defaults at once.
// Append and flush steps hold while the output register waits on byte_out.ready.
`timescale 1ns / 1ps
`include "hidden_bit_extract_packer_macros.svh"
module hidden_bit_extract_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	hbe_in_if.sink                        frame_in,
	hbe_out_if.source                     byte_out,
	input  logic                          cfg_we,
	input  logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbe_pkg::RATE_W-1:0]    cfg_data
);
	import hbe_pkg::*;

	hbe_cmd_t  cmd;
	hbe_stat_t stat;
	logic      in_ready;

	assign frame_in.ready = in_ready;

	hbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame_in.valid),
		.in_action (frame_in.action),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hbe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (frame_in.action),
		.in_bits   (frame_in.hidden_word),
		.in_count  (frame_in.frame_bit_count),
		.out_ready (byte_out.ready),
		.out_valid (byte_out.valid),
		.out_data  (byte_out.data_byte),
		.out_last  (byte_out.last_of_item),
		.cmd       (cmd),
		.stat      (stat)
	);

	`HBE_ASSERT_IMPL(a_busy_after_accept, clk, arst_n, frame_in.valid && frame_in.ready |=> !frame_in.ready, "word accepted while previous one still in work")
	`HBE_ASSERT_IMPL(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "more than one datapath command at once")
	`HBE_ASSERT_NEVER(a_append_blocked, clk, arst_n, (cmd.append || cmd.flush) && !stat.out_free, "append or flush while output register full")
endmodule

[rtl/core/hbe_ctrl.sv]
// Sequencer for the packer: steps grant, division, append and flush phases.
// Depends on hbe_pkg.
`timescale 1ns / 1ps
module hbe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	input  hbe_pkg::hbe_stat_t stat,
	output hbe_pkg::hbe_cmd_t  cmd
);
	import hbe_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SPF    = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_PLAN   = 3'd4;
	localparam logic [2:0] ST_APPEND = 3'd5;
	localparam logic [2:0] ST_FLUSH  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_action ? ST_FLUSH : ST_SPF;
				end
			end
			ST_SPF: begin
				cmd.spf = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_PLAN;
				end else begin
					cmd.div = 1'b1;
				end
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = ST_APPEND;
			end
			ST_APPEND: begin
				if (stat.rem_zero) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.append = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[rtl/core/hbe_dp.sv]
// Datapath: configuration registers, credit grant, sequence tracking, bit packer
// and output register. Depends on hbe_pkg.
`timescale 1ns / 1ps
module hbe_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hbe_pkg::RATE_W-1:0]        cfg_data,
	input  logic                              in_action,
	input  logic [7:0]                        in_bits,
	input  logic [7:0]                        in_count,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        out_data,
	output logic                              out_last,
	input  hbe_pkg::hbe_cmd_t                 cmd,
	output hbe_pkg::hbe_stat_t                stat
);
	import hbe_pkg::*;

	logic [BPS_W-1:0]    bps_q;
	logic [RATE_W-1:0]   rate_q;
	logic                seq_mode_q;
	logic [CREDIT_W-1:0] credit_q;
	logic [7:0]          pb_q;
	logic [2:0]          pc_q;
	logic [1:0]          exp_q;
	logic                synced_q;
	logic                out_valid_q;
	logic [7:0]          out_data_q;
	logic                out_last_q;
	logic [4:0]          rem_q;

	logic                action_q;
	logic [7:0]          bits_q;
	logic [7:0]          count_q;
	logic [SPF_W-1:0]    spf_q;
	logic [ACC_W-1:0]    acc_q;
	logic [2:0]          grant_q;
	logic [15:0]         stream_q;
	logic [2:0]          step_q;

	logic [32:0] spf_prod;
	logic [19:0] bps_prod;
	logic [2:0]  eff;
	logic        seq_case;
	logic [1:0]  gaps;
	logic [5:0]  chunk;
	logic [3:0]  sum;
	logic [15:0] wide;
	logic [4:0]  rem_after;
	logic [5:0]  tail_bits;
	logic        emit;

	assign spf_prod  = {17'b0, rate_q} * {16'b0, SPF_RECIP};
	assign bps_prod  = {11'b0, bps_q} * {9'b0, spf_q};
	assign eff       = (count_q > {5'b0, grant_q}) ? grant_q : count_q[2:0];
	assign seq_case  = seq_mode_q && (eff == MAX_GRANT);
	assign gaps      = synced_q ? (bits_q[5:4] - exp_q) : 2'd0;
	assign chunk     = stream_q[5:0] & ~(6'h3F << step_q);
	assign sum       = {1'b0, pc_q} + {1'b0, step_q};
	assign wide      = ({10'b0, chunk} << pc_q) | {8'b0, pb_q};
	assign rem_after = rem_q - {2'b0, step_q};
	assign tail_bits = {3'b0, sum[2:0]} + {1'b0, rem_after};
	assign emit      = cmd.append && sum[3];

	assign stat.div_done = (rate_q == '0) || (grant_q == MAX_GRANT) ||
		(acc_q < {5'b0, rate_q});
	assign stat.rem_zero = (rem_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q       <= DEFAULT_BPS;
			rate_q      <= DEFAULT_RATE;
			seq_mode_q  <= 1'b0;
			credit_q    <= '0;
			pb_q        <= '0;
			pc_q        <= '0;
			exp_q       <= '0;
			synced_q    <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BPS:  bps_q      <= cfg_data[BPS_W-1:0];
					REG_RATE: rate_q     <= cfg_data;
					REG_SEQ:  seq_mode_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.plan) begin
				credit_q <= (acc_q > ACC_W'(16'hFFFF)) ? 16'hFFFF : acc_q[CREDIT_W-1:0];
				if (seq_case) begin
					rem_q    <= {3'(gaps) + 3'd1, 2'b00};
					exp_q    <= bits_q[5:4] + 2'd1;
					synced_q <= 1'b1;
				end else begin
					rem_q <= {2'b0, eff};
				end
			end
			if (cmd.append) begin
				rem_q <= rem_after;
				if (sum[3]) begin
					pb_q <= wide[15:8];
					pc_q <= sum[2:0];
				end else begin
					pb_q <= wide[7:0];
					pc_q <= sum[2:0];
				end
			end
			if (cmd.flush) begin
				pb_q <= '0;
				pc_q <= '0;
			end
			if (emit || (cmd.flush && pc_q != '0)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			bits_q   <= in_bits;
			count_q  <= in_count;
		end
		if (cmd.spf) begin
			spf_q <= spf_prod[SPF_SHIFT +: SPF_W];
		end
		if (cmd.mul) begin
			acc_q   <= {5'b0, credit_q} + {1'b0, bps_prod};
			grant_q <= '0;
		end
		if (cmd.div) begin
			acc_q   <= acc_q - {5'b0, rate_q};
			grant_q <= grant_q + 3'd1;
		end
		if (cmd.plan) begin
			if (seq_case) begin
				stream_q <= {12'b0, bits_q[3:0]} << {gaps, 2'b00};
				step_q   <= NIBBLE_BITS;
			end else begin
				stream_q <= {8'b0, bits_q};
				step_q   <= eff;
			end
		end
		if (cmd.append) begin
			stream_q <= stream_q >> step_q;
		end
		if (emit) begin
			out_data_q <= wide[7:0];
			out_last_q <= (tail_bits < 6'd8);
		end else if (cmd.flush && action_q) begin
			out_data_q <= pb_q;
			out_last_q <= 1'b1;
		end
	end
endmodule

[tb/hbe_tb_pkg.sv]
`timescale 1ns / 1ps
// Types shared by the packer testbench: frame word actions and the byte word record.
// No dependencies.
package hbe_tb_pkg;
	typedef enum logic {
		ACT_FRAME = 1'b0,
		ACT_FLUSH = 1'b1
	} frame_action_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_item;
	} byte_word_t;
endpackage

[tb/hbe_byte_checker.sv]
`timescale 1ns / 1ps
// Watches the frame and byte channels and the register port, predicts the packed bytes
// and compares them in order. Depends on hbe_pkg, hbe_tb_pkg, hbe_in_if and hbe_out_if.
module hbe_byte_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	hbe_in_if                             frame_in,
	hbe_out_if                            byte_out,
	input  logic                          cfg_we,
	input  logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hbe_pkg::RATE_W-1:0]    cfg_data,
	output int                            bytes_due,
	output int                            fail_count
);
	import hbe_pkg::*;
	import hbe_tb_pkg::*;

	logic [BPS_W-1:0]    bps;
	logic [RATE_W-1:0]   rate;
	logic                seq_mode;
	logic [CREDIT_W-1:0] credit;
	logic [7:0]          part_byte;
	int unsigned         part_cnt;
	logic [1:0]          seq_next;
	logic                seq_locked;
	byte_word_t          due_q[$];
	byte_word_t          item_q[$];
	byte_word_t          got;
	byte_word_t          want;
	int                  fails;

	function automatic int unsigned grant_credit_bits();
		longint unsigned sum;
		longint unsigned allowed;
		if (rate == 0)
			return 0;
		sum = longint'(credit) + longint'(bps) * longint'(rate / FRAMES_PER_SEC);
		allowed = sum / rate;
		if (allowed > MAX_GRANT)
			allowed = MAX_GRANT;
		sum -= allowed * rate;
		if (sum > 64'hFFFF)
			sum = 64'hFFFF;
		credit = CREDIT_W'(sum);
		return int'(allowed);
	endfunction

	function automatic void pack_bits(logic [7:0] bits, int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			part_byte[part_cnt] = bits[i];
			part_cnt++;
			if (part_cnt == 8) begin
				item_q.push_back('{part_byte, 1'b0});
				part_byte = '0;
				part_cnt = 0;
			end
		end
	endfunction

	function automatic void pack_frame_word(frame_action_t act, logic [7:0] bits,
			logic [7:0] count);
		int unsigned n;
		logic [1:0]  seq;
		byte_word_t  tail;
		item_q.delete();
		if (act == ACT_FLUSH) begin
			if (part_cnt > 0)
				item_q.push_back('{part_byte, 1'b1});
			part_byte = '0;
			part_cnt = 0;
		end else begin
			n = grant_credit_bits();
			if (count < n)
				n = count;
			if (seq_mode && n >= 2 + NIBBLE_BITS) begin
				seq = bits[5:4];
				if (seq_locked) begin
					while (seq != seq_next) begin
						pack_bits(8'h00, NIBBLE_BITS);
						seq_next++;
					end
				end
				pack_bits({4'h0, bits[3:0]}, NIBBLE_BITS);
				if (!seq_locked) begin
					seq_next = seq;
					seq_locked = 1'b1;
				end
				seq_next++;
			end else if (n > 0) begin
				pack_bits(bits, n);
			end
			if (item_q.size() > 0) begin
				tail = item_q.pop_back();
				tail.last_of_item = 1'b1;
				item_q.push_back(tail);
			end
		end
		foreach (item_q[i])
			due_q.push_back(item_q[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps = DEFAULT_BPS;
			rate = DEFAULT_RATE;
			seq_mode = 1'b0;
			credit = '0;
			part_byte = '0;
			part_cnt = 0;
			seq_next = '0;
			seq_locked = 1'b0;
			due_q.delete();
			fails = 0;
			bytes_due <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BPS:  bps = cfg_data[BPS_W-1:0];
					REG_RATE: rate = cfg_data;
					REG_SEQ:  seq_mode = cfg_data[0];
					default:  ;
				endcase
			end
			if (frame_in.valid && frame_in.ready)
				pack_frame_word(frame_action_t'(frame_in.action), frame_in.hidden_word,
					frame_in.frame_bit_count);
			if (byte_out.valid && byte_out.ready) begin
				got = '{byte_out.data_byte, byte_out.last_of_item};
				if (due_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected byte %02h last %0b at %0t", got.data_byte,
							got.last_of_item, $realtime);
				end else begin
					want = due_q.pop_front();
					if (got.data_byte !== want.data_byte
							|| got.last_of_item !== want.last_of_item) begin
						fails++;
						if (fails <= 10)
							$display("byte mismatch at %0t: expected %02h last %0b, got %02h last %0b",
								$realtime, want.data_byte, want.last_of_item,
								got.data_byte, got.last_of_item);
					end
				end
			end
			bytes_due <= due_q.size();
			fail_count <= fails;
		end
	end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the packer testbench: clock, reset, register writes, frame words and byte stalls.
// Depends on hbe_pkg, hbe_tb_pkg, the channel interfaces, hbe_byte_checker and the block.
module tb_top;
	import hbe_pkg::*;
	import hbe_tb_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATE_W-1:0]    cfg_data;
	int                   bytes_due;
	int                   fail_count;
	int                   tx_gap_max;
	int                   rx_gap_max;
	int                   bytes_taken;
	int                   sent;
	logic [1:0]           tx_seq;
	logic                 seq_on;

	hbe_in_if  frame_in ();
	hbe_out_if byte_out ();

	hidden_bit_extract_packer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_in  (frame_in),
		.byte_out  (byte_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hbe_byte_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_in),
		.byte_out   (byte_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.bytes_due  (bytes_due),
		.fail_count (fail_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_word(frame_action_t act, logic [7:0] bits, logic [7:0] count);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			frame_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.action <= act;
		frame_in.hidden_word <= bits;
		frame_in.frame_bit_count <= count;
		do @(posedge clk); while (!frame_in.ready);
		sent++;
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned bps, int unsigned rate, logic seq);
		set_reg(REG_BPS, RATE_W'(bps));
		set_reg(REG_RATE, RATE_W'(rate));
		set_reg(REG_SEQ, RATE_W'(seq));
		cfg_we <= 1'b0;
		seq_on = seq;
	endtask

	// hold until every predicted byte is in or the wait gives up, then let the block go quiet
	task automatic drain();
		int k;
		frame_in.valid <= 1'b0;
		@(posedge clk);
		for (k = 0; k < 5000 && bytes_due != 0; k++)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_word();
		logic [7:0] bits;
		logic [7:0] count;
		if ($urandom_range(0, 19) == 0) begin
			send_word(ACT_FLUSH, 8'($urandom), 8'($urandom));
		end else begin
			if (seq_on && $urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 7) == 0)
					tx_seq = tx_seq + 2'($urandom_range(1, 3));
				bits = {2'($urandom), tx_seq, 4'($urandom)};
				tx_seq++;
				count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 5))
					: 8'($urandom_range(6, 255));
			end else begin
				bits = 8'($urandom);
				count = $urandom_range(0, 1) ? 8'($urandom_range(0, 8))
					: 8'($urandom_range(0, 255));
			end
			send_word(ACT_FRAME, bits, count);
		end
	endtask

	initial begin
		int unsigned bps;
		int unsigned rate;
		logic        seq;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		frame_in.valid <= 1'b0;
		frame_in.action <= ACT_FRAME;
		frame_in.hidden_word <= '0;
		frame_in.frame_bit_count <= '0;
		tx_gap_max = 6;
		rx_gap_max = 6;
		tx_seq = '0;
		seq_on = 1'b0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		configure(300, 48000, 1'b0);
		send_word(ACT_FLUSH, 8'hFF, 8'hFF);
		send_word(ACT_FRAME, 8'hFF, 8'h00);
		send_word(ACT_FRAME, 8'hA5, 8'hFF);
		send_word(ACT_FRAME, 8'h00, 8'h03);
		send_word(ACT_FLUSH, 8'hFF, 8'hFF);
		send_word(ACT_FRAME, 8'hFF, 8'h06);
		send_word(ACT_FRAME, 8'h3C, 8'h06);
		send_word(ACT_FRAME, 8'h5A, 8'h02);
		drain();
		configure(300, 48000, 1'b1);
		send_word(ACT_FRAME, {2'b11, 2'd2, 4'hA}, 8'h06);
		send_word(ACT_FRAME, {2'b00, 2'd3, 4'h5}, 8'hFF);
		send_word(ACT_FRAME, {2'b10, 2'd2, 4'hF}, 8'h06);
		send_word(ACT_FRAME, {2'b01, 2'd2, 4'h1}, 8'h07);
		send_word(ACT_FRAME, 8'hFF, 8'h05);
		send_word(ACT_FLUSH, 8'h00, 8'h00);
		drain();
		configure(0, 0, 1'b0);
		send_word(ACT_FRAME, 8'hFF, 8'hFF);
		drain();
		configure(300, 49, 1'b0);
		send_word(ACT_FRAME, 8'h81, 8'h08);
		drain();
		configure(300, 50, 1'b1);
		send_word(ACT_FRAME, 8'h2C, 8'h06);
		drain();
		configure(511, 65535, 1'b0);
		send_word(ACT_FRAME, 8'hFF, 8'hFF);
		send_word(ACT_FRAME, 8'h00, 8'hFF);
		send_word(ACT_FRAME, 8'h55, 8'hFF);
		send_word(ACT_FLUSH, 8'hFF, 8'h00);

		while (sent < 1650) begin
			seq = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0:       bps = 0;
				1:       bps = 511;
				2:       bps = 300;
				default: bps = seq ? $urandom_range(280, 511) : $urandom_range(0, 511);
			endcase
			case ($urandom_range(0, 9))
				0:       rate = 0;
				1:       rate = 65535;
				2:       rate = 48000;
				3:       rate = $urandom_range(1, 49);
				4:       rate = 50;
				default: rate = $urandom_range(50, 48000);
			endcase
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			drain();
			configure(bps, rate, seq);
			repeat ($urandom_range(60, 200)) random_word();
		end
		drain();

		if (fail_count == 0 && bytes_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int gap;
		byte_out.ready <= 1'b0;
		bytes_taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (bytes_taken == 100 || bytes_taken == 400)
				gap = 300;
			else
				gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				byte_out.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_out.ready <= 1'b1;
			do @(posedge clk); while (!byte_out.valid);
			bytes_taken++;
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

[hidden_bit_extract_packer.f]
+incdir+rtl/core
rtl/core/hbe_pkg.sv
rtl/core/hbe_in_if.sv
rtl/core/hbe_out_if.sv
rtl/core/hbe_ctrl.sv
rtl/core/hbe_dp.sv
rtl/core/hidden_bit_extract_packer.sv
tb/hbe_tb_pkg.sv
tb/hbe_byte_checker.sv
tb/tb_top.sv
